// ----- src/rhcc_pkg.sv -----
`timescale 1ns / 1ps

package rhcc_pkg;

  // default number of fractional bits of every result
  localparam int FRAC_BITS_DEF = 12;

  // fixed field widths
  localparam int CH_W  = 8;
  localparam int SUM_W = 9;
  localparam int DEN_W = 11;   // largest divisor is 6 * 255
  localparam int REM_W = 12;   // partial remainder stays below twice the divisor
  localparam int OUT_W = 13;

  // divider lanes
  localparam int LANES      = 2;
  localparam int LANE_HUE   = 0;
  localparam int LANE_SAT   = 1;

  localparam logic [DEN_W-1:0] LIGHT_DEN = 11'd510;
  localparam logic [SUM_W-1:0] SUM_HALF  = 9'd255;

  // window limits in hundredths of full scale
  localparam int unsigned PCT_RED_H_LO   = 85;
  localparam int unsigned PCT_GRN_H_LO   = 25;
  localparam int unsigned PCT_GRN_H_HI   = 45;
  localparam int unsigned PCT_BLU_H_LO   = 45;
  localparam int unsigned PCT_BLU_H_HI   = 60;
  localparam int unsigned PCT_L_LO       = 10;
  localparam int unsigned PCT_L_HI       = 90;
  localparam int unsigned PCT_BLU_L_HI   = 95;
  localparam int unsigned PCT_RED_S_LO   = 20;
  localparam int unsigned PCT_GB_S_LO    = 30;

  typedef enum logic [1:0] {
    CLS_NONE  = 2'd0,
    CLS_RED   = 2'd1,
    CLS_GREEN = 2'd2,
    CLS_BLUE  = 2'd3
  } color_class_t;

  // one divider lane: dividend (before scaling) and divisor
  typedef struct packed {
    logic [REM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_lane_t;

  // hundredths to fixed point, rounded half up
  function automatic int unsigned fx_hund(input int unsigned pct, input int unsigned frac);
    return ((pct << frac) + 50) / 100;
  endfunction

endpackage

// ----- src/rhcc_div_pipe.sv -----
`timescale 1ns / 1ps

module rhcc_div_pipe
  import rhcc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int QW = FRAC_BITS + 1,
  localparam int STAGES = FRAC_BITS + 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_vld,
  input  div_lane_t       lane_in [LANES],
  output logic            out_vld,
  output logic [QW-1:0]   quo [LANES]
);

  // restoring division, one quotient bit per stage, msb first
  logic                 vld [STAGES];
  logic [QW-1:0]        q   [STAGES][LANES];
  logic [REM_W-1:0]     rem [STAGES-1][LANES];
  logic [DEN_W-1:0]     den [STAGES-1][LANES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic                 v_in;
    logic [REM_W-1:0]     r_in [LANES];
    logic [DEN_W-1:0]     d_in [LANES];
    logic [QW-1:0]        q_in [LANES];

    if (s == 0) begin : g_first
      assign v_in = in_vld;
      for (genvar l = 0; l < LANES; l++) begin : g_lane
        assign r_in[l] = lane_in[l].num;
        assign d_in[l] = lane_in[l].den;
        assign q_in[l] = '0;
      end
    end else begin : g_next
      assign v_in = vld[s-1];
      for (genvar l = 0; l < LANES; l++) begin : g_lane
        assign r_in[l] = rem[s-1][l];
        assign d_in[l] = den[s-1][l];
        assign q_in[l] = q[s-1][l];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= v_in;
      end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_calc
      logic             ge;

      always_comb begin
        ge = r_in[l] >= REM_W'(d_in[l]);
      end

      always_ff @(posedge clk) begin
        if (en) begin
          q[s][l] <= {q_in[l][QW-2:0], ge};
        end
      end

      if (s < STAGES - 1) begin : g_carry
        logic [REM_W-1:0] diff;

        always_comb begin
          diff = ge ? (r_in[l] - REM_W'(d_in[l])) : r_in[l];
        end

        always_ff @(posedge clk) begin
          if (en) begin
            rem[s][l] <= {diff[REM_W-2:0], 1'b0};
            den[s][l] <= d_in[l];
          end
        end
      end
    end
  end

  assign out_vld = vld[STAGES-1];
  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign quo[l] = q[STAGES-1][l];
  end

endmodule

// ----- src/rgb_to_hls_color_classifier_unit.sv -----
`timescale 1ns / 1ps

// channel   direction  handshake                    payload
// color     in         color_valid / color_ready    red, green, blue (8 bits each)
// result    out        result_valid / result_ready  hue, lightness, saturation (13), color_class (2)
//
// one color per clock unless a result is stalled
// the divider pipeline computes one quotient bit per stage
// rst is synchronous and clears only the valid bits; payload registers hold junk
// a stalled result freezes the whole pipeline; color_ready falls with it and
// nothing is dropped or repeated

module rgb_to_hls_color_classifier_unit
  import rhcc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             color_valid,
  output logic             color_ready,
  input  logic [CH_W-1:0]  red,
  input  logic [CH_W-1:0]  green,
  input  logic [CH_W-1:0]  blue,
  output logic             result_valid,
  input  logic             result_ready,
  output logic [OUT_W-1:0] hue,
  output logic [OUT_W-1:0] lightness,
  output logic [OUT_W-1:0] saturation,
  output logic [1:0]       color_class
);

  localparam int QW = FRAC_BITS + 1;
  localparam int STAGES = FRAC_BITS + 1;

  // window limits in the result format
  localparam logic [QW-1:0] FX_ONE   = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [QW-1:0] TH_R_HLO = QW'(fx_hund(PCT_RED_H_LO, FRAC_BITS));
  localparam logic [QW-1:0] TH_G_HLO = QW'(fx_hund(PCT_GRN_H_LO, FRAC_BITS));
  localparam logic [QW-1:0] TH_G_HHI = QW'(fx_hund(PCT_GRN_H_HI, FRAC_BITS));
  localparam logic [QW-1:0] TH_B_HLO = QW'(fx_hund(PCT_BLU_H_LO, FRAC_BITS));
  localparam logic [QW-1:0] TH_B_HHI = QW'(fx_hund(PCT_BLU_H_HI, FRAC_BITS));
  localparam logic [QW-1:0] TH_LLO   = QW'(fx_hund(PCT_L_LO, FRAC_BITS));
  localparam logic [QW-1:0] TH_LHI   = QW'(fx_hund(PCT_L_HI, FRAC_BITS));
  localparam logic [QW-1:0] TH_B_LHI = QW'(fx_hund(PCT_BLU_L_HI, FRAC_BITS));
  localparam logic [QW-1:0] TH_R_SLO = QW'(fx_hund(PCT_RED_S_LO, FRAC_BITS));
  localparam logic [QW-1:0] TH_GB_SLO = QW'(fx_hund(PCT_GB_S_LO, FRAC_BITS));

  // lightness divides by a constant: reciprocal multiply, exact for every sum
  // since sum times the reciprocal's rounding error stays below 2^LIGHT_SHIFT
  localparam int LIGHT_SHIFT = 18;
  localparam int LM_W        = FRAC_BITS + 10;
  localparam int PROD_W      = SUM_W + LM_W;
  localparam logic [LM_W-1:0] LIGHT_MUL =
    LM_W'(((64'd1 << (FRAC_BITS + LIGHT_SHIFT)) + 64'(LIGHT_DEN) - 64'd1) / 64'(LIGHT_DEN));

  // which channel holds the maximum, red wins ties, then green
  typedef enum logic [1:0] {
    MAX_R,
    MAX_G,
    MAX_B
  } max_sel_t;

  // global advance: the pipeline moves unless a result is waiting
  logic en;
  assign en          = !result_valid || result_ready;
  assign color_ready = en;

  // ---------------------------------------------------------------
  // stage 1: max, min and which channel is max
  // ---------------------------------------------------------------
  logic            s1_vld;
  logic [CH_W-1:0] s1_r, s1_g, s1_b, s1_mx, s1_mn;
  max_sel_t        s1_sel;

  logic [CH_W-1:0] mx_c, mn_c;
  max_sel_t        sel_c;

  always_comb begin
    priority if (red >= green && red >= blue) begin
      mx_c  = red;
      sel_c = MAX_R;
    end else if (green >= blue) begin
      mx_c  = green;
      sel_c = MAX_G;
    end else begin
      mx_c  = blue;
      sel_c = MAX_B;
    end
    mn_c = red;
    if (green < mn_c) mn_c = green;
    if (blue < mn_c) mn_c = blue;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= color_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r   <= red;
      s1_g   <= green;
      s1_b   <= blue;
      s1_mx  <= mx_c;
      s1_mn  <= mn_c;
      s1_sel <= sel_c;
    end
  end

  // ---------------------------------------------------------------
  // stage 2: dividends and divisors for hue and saturation, sum for lightness
  // ---------------------------------------------------------------
  logic             s2_vld;
  div_lane_t        s2_lane [LANES];
  logic [SUM_W-1:0] s2_sum;

  logic [CH_W-1:0]  d_c;
  logic [SUM_W-1:0] sum_c;
  logic [REM_W-1:0] d_w, six_d, hue_num;
  logic [REM_W-1:0] r_w, g_w, b_w;
  logic [DEN_W-1:0] sat_den, hue_den;

  always_comb begin
    d_c   = s1_mx - s1_mn;
    sum_c = SUM_W'(s1_mx) + SUM_W'(s1_mn);
    d_w   = REM_W'(d_c);
    r_w   = REM_W'(s1_r);
    g_w   = REM_W'(s1_g);
    b_w   = REM_W'(s1_b);
    six_d = (d_w << 2) + (d_w << 1);

    // modular arithmetic; every selected sum lands in 0 .. 6d
    unique case (s1_sel)
      MAX_R:   hue_num = (s1_g >= s1_b) ? (g_w - b_w) : (six_d + g_w - b_w);
      MAX_G:   hue_num = (d_w << 1) + b_w - r_w;
      MAX_B:   hue_num = (d_w << 2) + r_w - g_w;
      default: hue_num = '0;
    endcase

    // gray gives a zero dividend, divisor forced nonzero so the quotient is zero
    if (d_c == '0) begin
      hue_den = DEN_W'(1);
      sat_den = DEN_W'(1);
    end else begin
      hue_den = DEN_W'(six_d);
      sat_den = (sum_c > SUM_HALF) ? (LIGHT_DEN - DEN_W'(sum_c)) : DEN_W'(sum_c);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (en) begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_lane[LANE_HUE]   <= '{num: hue_num, den: hue_den};
      s2_lane[LANE_SAT]   <= '{num: d_w, den: sat_den};
      s2_sum              <= sum_c;
    end
  end

  // ---------------------------------------------------------------
  // divider pipeline: FRAC_BITS + 1 stages, hue and saturation lanes side by side
  // ---------------------------------------------------------------
  logic          dv_vld;
  logic [QW-1:0] quo [LANES];

  rhcc_div_pipe #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_vld (s2_vld),
    .lane_in(s2_lane),
    .out_vld(dv_vld),
    .quo    (quo)
  );

  // ---------------------------------------------------------------
  // lightness: multiply in its own stage, then delayed to meet the divider
  // ---------------------------------------------------------------
  logic [PROD_W-1:0] light_prod;
  logic [QW-1:0]     light_dly [STAGES];

  assign light_prod = PROD_W'(s2_sum) * PROD_W'(LIGHT_MUL);

  always_ff @(posedge clk) begin
    if (en) begin
      light_dly[0] <= light_prod[LIGHT_SHIFT +: QW];
      for (int i = 1; i < STAGES; i++) begin
        light_dly[i] <= light_dly[i-1];
      end
    end
  end

  // ---------------------------------------------------------------
  // final stage: windows, priority red > green > blue, output register
  // ---------------------------------------------------------------
  logic         win_red, win_green, win_blue;
  color_class_t cls_c;
  logic [QW-1:0] qh, ql, qs;

  always_comb begin
    qh = quo[LANE_HUE];
    ql = light_dly[STAGES-1];
    qs = quo[LANE_SAT];
    win_red   = (qh >= TH_R_HLO) && (qh <= FX_ONE) &&
                (ql >= TH_LLO) && (ql <= TH_LHI) &&
                (qs >= TH_R_SLO) && (qs <= FX_ONE);
    win_green = (qh >= TH_G_HLO) && (qh <= TH_G_HHI) &&
                (ql >= TH_LLO) && (ql <= TH_LHI) &&
                (qs >= TH_GB_SLO) && (qs <= FX_ONE);
    win_blue  = (qh >= TH_B_HLO) && (qh <= TH_B_HHI) &&
                (ql >= TH_LLO) && (ql <= TH_B_LHI) &&
                (qs >= TH_GB_SLO) && (qs <= FX_ONE);
    priority if (win_red)   cls_c = CLS_RED;
    else if (win_green)     cls_c = CLS_GREEN;
    else if (win_blue)      cls_c = CLS_BLUE;
    else                    cls_c = CLS_NONE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= dv_vld;
    end
  end

  // results wider than the port keep their low bits
  always_ff @(posedge clk) begin
    if (en) begin
      hue         <= OUT_W'(qh);
      lightness   <= OUT_W'(ql);
      saturation  <= OUT_W'(qs);
      color_class <= cls_c;
    end
  end

endmodule

// ----- src/rhcc_checker.sv -----
`timescale 1ns / 1ps

module rhcc_checker
  import rhcc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input logic             clk,
  input logic             rst,
  input logic             color_valid,
  input logic             color_ready,
  input logic [CH_W-1:0]  red,
  input logic [CH_W-1:0]  green,
  input logic [CH_W-1:0]  blue,
  input logic             result_valid,
  input logic             result_ready,
  input logic [OUT_W-1:0] hue,
  input logic [OUT_W-1:0] lightness,
  input logic [OUT_W-1:0] saturation,
  input logic [1:0]       color_class
);

  // results reach the ports unmasked only up to twelve fractional bits
  localparam bit EXACT = FRAC_BITS <= 12;
  localparam logic [OUT_W-1:0] TH_R_HLO  = OUT_W'(fx_hund(PCT_RED_H_LO, FRAC_BITS));
  localparam logic [OUT_W-1:0] TH_R_SLO  = OUT_W'(fx_hund(PCT_RED_S_LO, FRAC_BITS));
  localparam logic [OUT_W-1:0] TH_G_HLO  = OUT_W'(fx_hund(PCT_GRN_H_LO, FRAC_BITS));
  localparam logic [OUT_W-1:0] TH_G_HHI  = OUT_W'(fx_hund(PCT_GRN_H_HI, FRAC_BITS));
  localparam logic [OUT_W-1:0] TH_LLO    = OUT_W'(fx_hund(PCT_L_LO, FRAC_BITS));

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(hue) &&
      $stable(lightness) && $stable(saturation) && $stable(color_class))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  a_red: assert property (@(posedge clk) disable iff (rst)
    EXACT && result_valid && color_class == CLS_RED |->
      hue >= TH_R_HLO && saturation >= TH_R_SLO && lightness >= TH_LLO)
    else $error("red class outside its window");

  a_green: assert property (@(posedge clk) disable iff (rst)
    EXACT && result_valid && color_class == CLS_GREEN |->
      hue >= TH_G_HLO && hue <= TH_G_HHI)
    else $error("green class outside its hue window");

  a_gray: assert property (@(posedge clk) disable iff (rst)
    EXACT && result_valid && saturation == '0 |-> color_class == CLS_NONE)
    else $error("unsaturated color got a class");

endmodule

bind rgb_to_hls_color_classifier_unit rhcc_checker #(.FRAC_BITS(FRAC_BITS)) u_rhcc_checker (.*);
